// ===== rtl/core/tick_ladder_price_index_map_macros.svh =====
// Assertion macros used by the tick ladder price/index map top module.
`ifndef TICK_LADDER_PRICE_INDEX_MAP_MACROS_SVH
`define TICK_LADDER_PRICE_INDEX_MAP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlp_pkg.sv =====
// Package with types, register codes and constants of the tick ladder price/index map.
package tlp_pkg;

  localparam int PRICE_W          = 32;
  localparam int NUM_REGS         = 7;
  localparam int CFG_IDX_W        = 3;
  localparam int DEF_NUM_BRACKETS = 3;
  localparam int DEF_PRICE_BITS   = 32;
  localparam int DIV_CNT_W        = $clog2(PRICE_W);

  localparam logic [PRICE_W-1:0] RST_BOUND_ONE = 32'd1000;
  localparam logic [PRICE_W-1:0] RST_BOUND_TWO = 32'd100000;
  localparam logic [PRICE_W-1:0] RST_TICK      = 32'd1;
  localparam logic [PRICE_W-1:0] IDX_MAX       = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW  = 3'd0,
    REG_BAND_HIGH = 3'd1,
    REG_BOUND_ONE = 3'd2,
    REG_BOUND_TWO = 3'd3,
    REG_TICK_ZERO = 3'd4,
    REG_TICK_ONE  = 3'd5,
    REG_TICK_TWO  = 3'd6
  } cfg_reg_t;

  // Ladder build sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_DIV,
    B_STORE,
    B_CUT
  } bld_state_t;

  typedef struct packed {
    logic               req_type;
    logic [PRICE_W-1:0] price;
    logic [PRICE_W-1:0] level_index;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] found_index;
    logic [PRICE_W-1:0] found_price;
    logic [PRICE_W-1:0] total_levels;
  } res_t;

  // One ladder segment; lim is offset plus count.
  typedef struct packed {
    logic               present;
    logic [PRICE_W-1:0] start;
    logic [PRICE_W-1:0] last;
    logic [PRICE_W-1:0] tick;
    logic [PRICE_W-1:0] offset;
    logic [PRICE_W-1:0] lim;
  } seg_t;

  // Request fields that ride along the divider chain.
  typedef struct packed {
    logic               req_type;
    logic               found;
    logic [PRICE_W-1:0] key;
    logic [PRICE_W-1:0] base;
    logic [PRICE_W-1:0] prod;
  } pay_t;

  // Contents of one divider cell.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] rem;
    logic [PRICE_W-1:0] numq;
    logic [PRICE_W-1:0] divisor;
    pay_t               pay;
  } cell_t;

endpackage

// ===== rtl/core/tick_ladder_price_index_map.sv =====
// Pipeline: the select register loads on the accepting edge, then the multiply stage, 32
// divider cells and the output register follow. Throughput: one request per cycle while
// the output is not stalled and no build runs; the 32-cell restoring divider chain is fully
// pipelined. A register write rebuilds the ladder one segment at a time, each level count
// found by a bit-serial division; requests are not accepted while the build runs.
// Reset is synchronous, active low: registers return to defaults and no segment exists.
module tick_ladder_price_index_map #(
  parameter int NUM_BRACKETS = tlp_pkg::DEF_NUM_BRACKETS,
  parameter int PRICE_BITS   = tlp_pkg::DEF_PRICE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tlp_pkg::req_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlp_pkg::res_t                 out_data,
  input  logic                          cfg_we,
  input  logic [tlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlp_pkg::PRICE_W-1:0]   cfg_wdata
);
  import tlp_pkg::*;
  `include "tick_ladder_price_index_map_macros.svh"

  logic               busy;
  seg_t               segs [NUM_BRACKETS];
  logic [PRICE_W-1:0] level_total;
  logic               adv;

  tlp_builder #(
    .NUM_BRACKETS (NUM_BRACKETS),
    .PRICE_BITS   (PRICE_BITS)
  ) u_builder (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .busy        (busy),
    .segs        (segs),
    .level_total (level_total)
  );

  // The whole pipeline moves when the output register is free or being drained.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !busy;

  // Segment selection for the incoming request.
  logic               sel_found;
  logic [PRICE_W-1:0] sel_x, sel_base, sel_tick;

  always_comb begin
    sel_found = 1'b0;
    sel_x     = '0;
    sel_base  = '0;
    sel_tick  = RST_TICK;
    for (int k = 0; k < NUM_BRACKETS; k++) begin
      if (!sel_found && segs[k].present) begin
        if (!in_data.req_type) begin
          if (in_data.price >= segs[k].start && in_data.price <= segs[k].last) begin
            sel_found = 1'b1;
            sel_x     = in_data.price - segs[k].start;
            sel_base  = segs[k].offset;
            sel_tick  = segs[k].tick;
          end
        end else if (in_data.level_index >= segs[k].offset &&
                     in_data.level_index < segs[k].lim) begin
          sel_found = 1'b1;
          sel_x     = in_data.level_index - segs[k].offset;
          sel_base  = segs[k].start;
          sel_tick  = segs[k].tick;
        end
      end
    end
  end

  // Select stage register.
  logic               s0_valid_r;
  logic               s0_type_r, s0_found_r;
  logic [PRICE_W-1:0] s0_key_r, s0_base_r, s0_x_r, s0_tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_type_r  <= in_data.req_type;
      s0_found_r <= sel_found;
      s0_key_r   <= in_data.req_type ? in_data.level_index : in_data.price;
      s0_base_r  <= sel_base;
      s0_x_r     <= sel_x;
      s0_tick_r  <= sel_tick;
    end
  end

  // Multiply stage: index-to-price product, and loading of the divider chain.
  logic [PRICE_W-1:0] prod;
  cell_t              c_head_nxt;
  cell_t              c_head_r;
  logic               c_head_valid_r;

  assign prod = s0_x_r * s0_tick_r;

  always_comb begin
    c_head_nxt              = '0;
    c_head_nxt.valid        = s0_valid_r;
    c_head_nxt.rem          = '0;
    c_head_nxt.numq         = s0_type_r ? '0 : s0_x_r;
    c_head_nxt.divisor      = s0_tick_r;
    c_head_nxt.pay.req_type = s0_type_r;
    c_head_nxt.pay.found    = s0_found_r;
    c_head_nxt.pay.key      = s0_key_r;
    c_head_nxt.pay.base     = s0_base_r;
    c_head_nxt.pay.prod     = prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_head_valid_r <= 1'b0;
    end else if (adv) begin
      c_head_valid_r <= c_head_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_head_r <= c_head_nxt;
    end
  end

  // Divider chain: one quotient bit per cell.
  cell_t chain [PRICE_W+1];

  always_comb begin
    chain[0]       = c_head_r;
    chain[0].valid = c_head_valid_r;
  end

  for (genvar g = 0; g < PRICE_W; g++) begin : g_cell
    tlp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  // Result assembly and output register.
  cell_t              tail;
  res_t               res_nxt;
  res_t               res_r;
  logic               out_valid_r;
  logic [PRICE_W-1:0] addend;

  assign tail   = chain[PRICE_W];
  assign addend = tail.pay.req_type ? tail.pay.prod : tail.numq;

  always_comb begin
    res_nxt              = '0;
    res_nxt.total_levels = level_total;
    if (tail.pay.req_type) begin
      if (tail.pay.found) begin
        res_nxt.hit         = 1'b1;
        res_nxt.found_index = tail.pay.key;
        res_nxt.found_price = tail.pay.base + addend;
      end
    end else if (tail.pay.found && tail.rem == '0) begin
      res_nxt.hit         = 1'b1;
      res_nxt.found_index = tail.pay.base + addend;
      res_nxt.found_price = tail.pay.key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Checks on the block's own logic.
  `TLP_ASSERT_NOW(a_no_accept_in_build, in_ready, !busy, "request taken during ladder build")
  `TLP_ASSERT_NOW(a_miss_zero, out_valid && !out_data.hit,
                  out_data.found_index == '0 && out_data.found_price == '0,
                  "miss result carries nonzero values")
  `TLP_ASSERT_NEXT(a_cfg_starts_build, cfg_we && cfg_index != 3'(NUM_REGS), busy,
                   "register write did not start a ladder build")

endmodule

// ===== rtl/core/tlp_div_cell.sv =====
// One restoring-division cell: retires one quotient bit and passes the request on.
module tlp_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  tlp_pkg::cell_t cell_in,
  output tlp_pkg::cell_t cell_out
);
  import tlp_pkg::*;

  logic               valid_r;
  cell_t              data_r;
  cell_t              data_nxt;
  logic [PRICE_W:0]   trial;
  logic [PRICE_W:0]   diff;
  logic               qbit;

  // Shift the next dividend bit into the remainder and try to subtract.
  always_comb begin
    trial    = {cell_in.rem, cell_in.numq[PRICE_W-1]};
    diff     = trial - {1'b0, cell_in.divisor};
    qbit     = (trial >= {1'b0, cell_in.divisor});
    data_nxt = cell_in;
    data_nxt.rem  = qbit ? diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
    data_nxt.numq = {cell_in.numq[PRICE_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule

// ===== rtl/core/tlp_builder.sv =====
// Configuration registers and the sequencer that rebuilds the ladder segments.
module tlp_builder #(
  parameter int NUM_BRACKETS = tlp_pkg::DEF_NUM_BRACKETS,
  parameter int PRICE_BITS   = tlp_pkg::DEF_PRICE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlp_pkg::PRICE_W-1:0]    cfg_wdata,
  output logic                           busy,
  output tlp_pkg::seg_t                  segs [NUM_BRACKETS],
  output logic [tlp_pkg::PRICE_W-1:0]    level_total
);
  import tlp_pkg::*;

  localparam logic [63:0] PMASK = (64'd1 << PRICE_BITS) - 64'd1;
  localparam int          NW    = $clog2(NUM_BRACKETS + 1);
  localparam int          SW    = (NUM_BRACKETS > 1) ? $clog2(NUM_BRACKETS) : 1;

  logic [PRICE_W-1:0] regs_r [NUM_REGS];
  logic [PRICE_W-1:0] regs_nxt [NUM_REGS];
  seg_t               segs_r [NUM_BRACKETS];
  seg_t               segs_nxt [NUM_BRACKETS];
  logic [PRICE_W-1:0] total_r, total_nxt;
  bld_state_t         state_r, state_nxt;
  logic [PRICE_W:0]   cur_r, cur_nxt;
  logic [PRICE_W-1:0] off_r, off_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [PRICE_W-1:0] step_r, step_nxt;
  logic [PRICE_W-1:0] last_r, last_nxt;
  logic [PRICE_W-1:0] room_r, room_nxt;
  logic [PRICE_W-1:0] drem_r, drem_nxt;
  logic [PRICE_W-1:0] dnq_r, dnq_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [PRICE_W-1:0] prod_r, prod_nxt;

  logic [PRICE_W-1:0] cur32, t0, t1, t2, step, bound, last, room, wmask;
  logic               bounded;
  logic [PRICE_W:0]   trial, cnt33, sum33;
  logic [PRICE_W-1:0] mul;

  assign cur32 = cur_r[PRICE_W-1:0];
  assign wmask = PMASK[PRICE_W-1:0];
  assign t0    = (regs_r[REG_TICK_ZERO] == '0) ? RST_TICK : regs_r[REG_TICK_ZERO];
  assign t1    = (regs_r[REG_TICK_ONE] == '0) ? RST_TICK : regs_r[REG_TICK_ONE];
  assign t2    = (regs_r[REG_TICK_TWO] == '0) ? RST_TICK : regs_r[REG_TICK_TWO];

  // Bracket search and end of the segment that starts at the current price.
  always_comb begin
    bounded = 1'b1;
    bound   = regs_r[REG_BOUND_ONE];
    step    = t0;
    if (regs_r[REG_BOUND_ONE] > cur32) begin
      step  = t0;
      bound = regs_r[REG_BOUND_ONE];
    end else if (regs_r[REG_BOUND_TWO] > cur32) begin
      step  = t1;
      bound = regs_r[REG_BOUND_TWO];
    end else begin
      step    = t2;
      bounded = 1'b0;
    end
    if (!bounded) begin
      last = regs_r[REG_BAND_HIGH];
    end else if ((bound - cur32) < step) begin
      last = cur32;
    end else if ((bound - step) < regs_r[REG_BAND_HIGH]) begin
      last = bound - step;
    end else begin
      last = regs_r[REG_BAND_HIGH];
    end
    room = IDX_MAX - off_r;
  end

  assign trial = {drem_r, dnq_r[PRICE_W-1]};
  assign cnt33 = {1'b0, dnq_r} + {{PRICE_W{1'b0}}, 1'b1};
  assign sum33 = {1'b0, last_r} + {1'b0, step_r};
  assign mul   = (room_r - RST_TICK) * step_r;

  // Build sequencer next state.
  always_comb begin
    regs_nxt  = regs_r;
    segs_nxt  = segs_r;
    total_nxt = total_r;
    state_nxt = state_r;
    cur_nxt   = cur_r;
    off_nxt   = off_r;
    n_nxt     = n_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    room_nxt  = room_r;
    drem_nxt  = drem_r;
    dnq_nxt   = dnq_r;
    dcnt_nxt  = dcnt_r;
    prod_nxt  = prod_r;

    case (state_r)
      B_IDLE: begin
      end
      B_SETUP: begin
        if (n_r == NW'(NUM_BRACKETS) || cur_r > {1'b0, regs_r[REG_BAND_HIGH]} ||
            room == '0) begin
          total_nxt = off_r;
          state_nxt = B_IDLE;
        end else begin
          step_nxt  = step;
          last_nxt  = last;
          room_nxt  = room;
          drem_nxt  = '0;
          dnq_nxt   = last - cur32;
          dcnt_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (trial >= {1'b0, step_r}) begin
          drem_nxt = PRICE_W'(trial - {1'b0, step_r});
          dnq_nxt  = {dnq_r[PRICE_W-2:0], 1'b1};
        end else begin
          drem_nxt = trial[PRICE_W-1:0];
          dnq_nxt  = {dnq_r[PRICE_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(PRICE_W - 1)) begin
          state_nxt = B_STORE;
        end
      end
      B_STORE: begin
        if (cnt33 > {1'b0, room_r}) begin
          prod_nxt  = mul;
          state_nxt = B_CUT;
        end else begin
          segs_nxt[n_r[SW-1:0]].present = 1'b1;
          segs_nxt[n_r[SW-1:0]].start   = cur32;
          segs_nxt[n_r[SW-1:0]].last    = last_r;
          segs_nxt[n_r[SW-1:0]].tick    = step_r;
          segs_nxt[n_r[SW-1:0]].offset  = off_r;
          segs_nxt[n_r[SW-1:0]].lim     = off_r + cnt33[PRICE_W-1:0];
          off_nxt = off_r + cnt33[PRICE_W-1:0];
          n_nxt   = n_r + 1'b1;
          if ({{(64-PRICE_W-1){1'b0}}, sum33} > PMASK) begin
            total_nxt = off_r + cnt33[PRICE_W-1:0];
            state_nxt = B_IDLE;
          end else begin
            cur_nxt   = sum33;
            state_nxt = B_SETUP;
          end
        end
      end
      B_CUT: begin
        segs_nxt[n_r[SW-1:0]].present = 1'b1;
        segs_nxt[n_r[SW-1:0]].start   = cur32;
        segs_nxt[n_r[SW-1:0]].last    = cur32 + prod_r;
        segs_nxt[n_r[SW-1:0]].tick    = step_r;
        segs_nxt[n_r[SW-1:0]].offset  = off_r;
        segs_nxt[n_r[SW-1:0]].lim     = off_r + room_r;
        total_nxt = off_r + room_r;
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // A register write restarts the build from the low end of the band.
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAND_LOW, REG_BAND_HIGH, REG_BOUND_ONE, REG_BOUND_TWO,
        REG_TICK_ZERO, REG_TICK_ONE, REG_TICK_TWO: begin
          regs_nxt[cfg_index] = cfg_wdata & wmask;
          for (int k = 0; k < NUM_BRACKETS; k++) begin
            segs_nxt[k].present = 1'b0;
          end
          total_nxt = '0;
          off_nxt   = '0;
          n_nxt     = '0;
          cur_nxt   = {1'b0, regs_nxt[REG_BAND_LOW]};
          state_nxt = B_SETUP;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_BAND_LOW]  <= '0;
      regs_r[REG_BAND_HIGH] <= '0;
      regs_r[REG_BOUND_ONE] <= RST_BOUND_ONE & wmask;
      regs_r[REG_BOUND_TWO] <= RST_BOUND_TWO & wmask;
      regs_r[REG_TICK_ZERO] <= RST_TICK;
      regs_r[REG_TICK_ONE]  <= RST_TICK;
      regs_r[REG_TICK_TWO]  <= RST_TICK;
      for (int k = 0; k < NUM_BRACKETS; k++) begin
        segs_r[k] <= '0;
      end
      total_r <= '0;
      state_r <= B_IDLE;
      n_r     <= '0;
      off_r   <= '0;
      cur_r   <= '0;
      dcnt_r  <= '0;
    end else begin
      regs_r  <= regs_nxt;
      segs_r  <= segs_nxt;
      total_r <= total_nxt;
      state_r <= state_nxt;
      n_r     <= n_nxt;
      off_r   <= off_nxt;
      cur_r   <= cur_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // Working values of the build; no reset needed.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    last_r <= last_nxt;
    room_r <= room_nxt;
    drem_r <= drem_nxt;
    dnq_r  <= dnq_nxt;
    prod_r <= prod_nxt;
  end

  assign busy        = (state_r != B_IDLE);
  assign segs        = segs_r;
  assign level_total = total_r;

endmodule
